/* design/dwne_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dwne_pkg;

  localparam int unsigned MAX_BINS_DEF       = 65536;
  localparam int unsigned TIME_FRAC_BITS_DEF = 16;
  localparam int unsigned OUT_FRAC_BITS_DEF  = 16;

  localparam logic [25:0] TAU_Q24         = 26'd36859226;
  localparam logic [31:0] INV_TAU_LN2_Q32 = 32'd2820382969;
  localparam logic [31:0] LN2_Q32         = 32'd2977044472;
  localparam logic [3:0]  EXP_TERMS       = 4'd12;

  localparam int unsigned NUM_W   = 256;
  localparam int unsigned DEN_W   = 90;
  localparam int unsigned Q_W     = 48;
  localparam int unsigned ITER_W  = 9;
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned OP_W    = 5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_START  = 2'd1;
  localparam logic [1:0] ST_NO_END    = 2'd2;
  localparam logic [1:0] ST_ZERO_WIN  = 2'd3;

  localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
  localparam logic [OP_W-1:0] OP_BIN      = 5'd1;
  localparam logic [OP_W-1:0] OP_EX_MUL   = 5'd2;
  localparam logic [OP_W-1:0] OP_EX_SPLIT = 5'd3;
  localparam logic [OP_W-1:0] OP_EX_MULG  = 5'd4;
  localparam logic [OP_W-1:0] OP_EX_SETG  = 5'd5;
  localparam logic [OP_W-1:0] OP_HP_MUL   = 5'd6;
  localparam logic [OP_W-1:0] OP_HP_DIV   = 5'd7;
  localparam logic [OP_W-1:0] OP_HP_ACC   = 5'd8;
  localparam logic [OP_W-1:0] OP_EX_FIN   = 5'd9;
  localparam logic [OP_W-1:0] OP_CMP      = 5'd10;
  localparam logic [OP_W-1:0] OP_N0       = 5'd11;
  localparam logic [OP_W-1:0] OP_N1       = 5'd12;
  localparam logic [OP_W-1:0] OP_N2       = 5'd13;
  localparam logic [OP_W-1:0] OP_D0       = 5'd14;
  localparam logic [OP_W-1:0] OP_D1       = 5'd15;
  localparam logic [OP_W-1:0] OP_D2       = 5'd16;
  localparam logic [OP_W-1:0] OP_BIG_DIV  = 5'd17;
  localparam logic [OP_W-1:0] OP_LOAD_OUT = 5'd18;

  localparam logic [2:0] CFG_START  = 3'd0;
  localparam logic [2:0] CFG_END    = 3'd1;
  localparam logic [2:0] CFG_FRAMES = 3'd2;

  typedef struct packed {
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic [31:0] good_frames;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            exp_sel;
  } cmd_t;

  typedef struct packed {
    logic       pre_bad;
    logic       zero_win;
    logic       k_last;
    logic       div_busy;
  } sts_t;

endpackage

`default_nettype wire

/* design/decay_window_normalisation_estimate_unit.sv */
// Decay window normalization estimate.
// Histogram bins arrive on the in_ channel (left edge, right edge, count, last
// flag); a request is taken when in_valid is high and in_stall is low. Bins that
// are not the last one are absorbed at one per cycle while idle, with no result.
// The last bin of a histogram produces exactly one result on the out_ channel:
// the normalization constant in unsigned Q32.16 and a status code.
// When the start or end of the window is not found, the check state goes straight
// to the result state. Otherwise two exponentials are evaluated, each a 12-step
// Horner chain whose steps are a multiply, a division by the step index done as a
// reciprocal multiply, and an accumulate; a zero window then goes to the result
// state. A valid window adds a restoring division of the wide numerator; in_stall
// stays high until the result is loaded. The user writes the window and frame count
// through the APB port only while idle; the block itself does not enforce this.
// A finished result sits in an output register; the block takes new bins while
// it waits, and only the next result waits for out_stall to drop.
// Synchronous active-low reset clears the histogram state, sets the window to
// zero and the frame count to one, and drops out_valid.
`timescale 1ns / 1ps
`default_nettype none

module decay_window_normalisation_estimate_unit #(
  parameter int unsigned MAX_BINS       = dwne_pkg::MAX_BINS_DEF,
  parameter int unsigned TIME_FRAC_BITS = dwne_pkg::TIME_FRAC_BITS_DEF,
  parameter int unsigned OUT_FRAC_BITS  = dwne_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_bin_left_edge,
  input  wire logic [31:0] in_bin_right_edge,
  input  wire logic [31:0] in_bin_count,
  input  wire logic        in_last_bin,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [47:0]      out_norm_constant,
  output logic [1:0]       out_status,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  dwne_pkg::cfg_t cfg_r;
  dwne_pkg::cmd_t cmd;
  dwne_pkg::sts_t sts;
  logic [2:0]     reg_idx;

  assign reg_idx = {1'b0, paddr[3:2]};
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_time  <= '0;
      cfg_r.end_time    <= '0;
      cfg_r.good_frames <= 32'd1;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        dwne_pkg::CFG_START:  cfg_r.start_time  <= pwdata;
        dwne_pkg::CFG_END:    cfg_r.end_time    <= pwdata;
        dwne_pkg::CFG_FRAMES: cfg_r.good_frames <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dwne_pkg::CFG_START:  prdata = cfg_r.start_time;
      dwne_pkg::CFG_END:    prdata = cfg_r.end_time;
      dwne_pkg::CFG_FRAMES: prdata = cfg_r.good_frames;
      default:              prdata = '0;
    endcase
  end

  dwne_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .last_bin  (in_last_bin),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  dwne_dp #(
    .MAX_BINS       (MAX_BINS),
    .TIME_FRAC_BITS (TIME_FRAC_BITS),
    .OUT_FRAC_BITS  (OUT_FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .cmd            (cmd),
    .sts            (sts),
    .bin_left_edge  (in_bin_left_edge),
    .bin_right_edge (in_bin_right_edge),
    .bin_count      (in_bin_count),
    .last_bin       (in_last_bin),
    .norm_constant  (out_norm_constant),
    .status         (out_status)
  );

endmodule

`default_nettype wire

/* design/dwne_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module dwne_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [dwne_pkg::NUM_W-1:0]    num_in,
  input  wire logic [dwne_pkg::DEN_W-1:0]    den_in,
  input  wire logic [dwne_pkg::ITER_W-1:0]   iters,
  output logic                               busy,
  output logic [dwne_pkg::Q_W-1:0]           quot,
  output logic                               sat
);

  logic [dwne_pkg::NUM_W-1:0]  num_r, num_nxt;
  logic [dwne_pkg::DEN_W-1:0]  den_r;
  logic [dwne_pkg::DEN_W-1:0]  rem_r, rem_nxt;
  logic [dwne_pkg::ITER_W-1:0] cnt_r, cnt_nxt;
  logic [dwne_pkg::Q_W-1:0]    q_r, q_nxt;
  logic                        sat_r, sat_nxt;
  logic                        busy_r, busy_nxt;
  logic [dwne_pkg::DEN_W:0]    rem_sh;
  logic                        ge;
  logic [dwne_pkg::Q_W:0]      q_sh;

  always_comb begin
    rem_sh   = {rem_r, num_r[dwne_pkg::NUM_W-1]};
    ge       = rem_sh >= {1'b0, den_r};
    q_sh     = {q_r, ge};
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    sat_nxt  = sat_r;
    busy_nxt = busy_r;
    if (start) begin
      num_nxt  = num_in;
      rem_nxt  = '0;
      cnt_nxt  = iters;
      q_nxt    = '0;
      sat_nxt  = 1'b0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[dwne_pkg::NUM_W-2:0], 1'b0};
      rem_nxt = ge ? dwne_pkg::DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[dwne_pkg::DEN_W-1:0];
      if (!sat_r) begin
        if (q_sh[dwne_pkg::Q_W]) begin
          sat_nxt = 1'b1;
        end else begin
          q_nxt = q_sh[dwne_pkg::Q_W-1:0];
        end
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == dwne_pkg::ITER_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    sat_r <= sat_nxt;
    if (start) begin
      den_r <= den_in;
    end
  end

  assign busy = busy_r;
  assign quot = q_r;
  assign sat  = sat_r;

endmodule

`default_nettype wire

/* design/dwne_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module dwne_dp #(
  parameter int unsigned MAX_BINS       = dwne_pkg::MAX_BINS_DEF,
  parameter int unsigned TIME_FRAC_BITS = dwne_pkg::TIME_FRAC_BITS_DEF,
  parameter int unsigned OUT_FRAC_BITS  = dwne_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire dwne_pkg::cfg_t   cfg,
  input  wire dwne_pkg::cmd_t   cmd,
  output dwne_pkg::sts_t        sts,
  input  wire logic [31:0]      bin_left_edge,
  input  wire logic [31:0]      bin_right_edge,
  input  wire logic [31:0]      bin_count,
  input  wire logic             last_bin,
  output logic [47:0]           norm_constant,
  output logic [1:0]            status
);

  localparam int unsigned BIN_W     = $clog2(MAX_BINS + 1);
  localparam int unsigned NUM_SHIFT = 56 + OUT_FRAC_BITS - TIME_FRAC_BITS;
  localparam logic [47:0] MAX48     = 48'hFFFF_FFFF_FFFF;

  logic [47:0]      sum_r;
  logic [BIN_W-1:0] bin_num_r;
  logic [31:0]      width_r;
  logic             start_seen_r, end_seen_r;
  logic [47:0]      sum_fin_r;
  logic [31:0]      width_fin_r;
  logic [1:0]       pre_status_r;

  logic             first, start_ok, start_seen_n, end_seen_n;
  logic [31:0]      width_n;
  logic [48:0]      sum_add;
  logic [47:0]      sum_n;

  logic [dwne_pkg::MUL_P_W-1:0] mul_r;
  logic [dwne_pkg::MUL_A_W-1:0] mul_a;
  logic [dwne_pkg::MUL_B_W-1:0] mul_b;
  logic                         mul_en;

  logic [63:0] xv;
  logic        n_big_r;
  logic [5:0]  n_r;
  logic [31:0] f_r;
  logic [31:0] g_r;
  logic [32:0] acc_r;
  logic [3:0]  k_r;
  logic [31:0] ea_r, eb_r, diff_r;
  logic [32:0] acc_sh;
  logic [31:0] e_val;
  logic [79:0] num_acc_r;
  logic [57:0] den1_r;
  logic [dwne_pkg::DEN_W-1:0] den_acc_r;
  logic [31:0] frames_eff;

  logic [32:0] recip_k;
  logic [2:0]  shift_k;
  logic [31:0] hp_q;

  logic                         div_start;
  logic [dwne_pkg::NUM_W-1:0]   div_num;
  logic [dwne_pkg::DEN_W-1:0]   div_den;
  logic [dwne_pkg::ITER_W-1:0]  div_iters;
  logic                         div_busy;
  logic [dwne_pkg::Q_W-1:0]     div_q;
  logic                         div_sat;

  logic [47:0] norm_r;
  logic [1:0]  status_r;

  always_comb begin
    first        = (bin_num_r == '0);
    start_ok     = first ? (bin_left_edge > cfg.start_time)
                         : (bin_left_edge >= cfg.start_time);
    start_seen_n = start_seen_r | start_ok;
    end_seen_n   = end_seen_r | (!first && (bin_right_edge <= cfg.end_time))
                 | (last_bin && (bin_right_edge < cfg.end_time));
    width_n      = (bin_right_edge >= bin_left_edge) ? (bin_right_edge - bin_left_edge) : '0;
    sum_add      = {1'b0, sum_r} + {17'b0, bin_count};
    if (start_ok && (bin_right_edge <= cfg.end_time)) begin
      sum_n = sum_add[48] ? MAX48 : sum_add[47:0];
    end else begin
      sum_n = sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r        <= '0;
      bin_num_r    <= '0;
      width_r      <= '0;
      start_seen_r <= 1'b0;
      end_seen_r   <= 1'b0;
      pre_status_r <= dwne_pkg::ST_OK;
    end else if (cmd.op == dwne_pkg::OP_BIN) begin
      if (last_bin) begin
        sum_r        <= '0;
        bin_num_r    <= '0;
        width_r      <= '0;
        start_seen_r <= 1'b0;
        end_seen_r   <= 1'b0;
        if (!start_seen_n) begin
          pre_status_r <= dwne_pkg::ST_NO_START;
        end else if (!end_seen_n) begin
          pre_status_r <= dwne_pkg::ST_NO_END;
        end else begin
          pre_status_r <= dwne_pkg::ST_OK;
        end
      end else begin
        sum_r        <= sum_n;
        start_seen_r <= start_seen_n;
        end_seen_r   <= end_seen_n;
        if (first) begin
          width_r <= width_n;
        end
        if (bin_num_r < BIN_W'(MAX_BINS)) begin
          bin_num_r <= bin_num_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == dwne_pkg::OP_BIN && last_bin) begin
      sum_fin_r   <= sum_n;
      width_fin_r <= first ? width_n : width_r;
    end
  end

  assign frames_eff = (cfg.good_frames == '0) ? 32'd1 : cfg.good_frames;

  // Division of a 32-bit value by k is a multiply by ceil(2^(32+s)/k), s = ceil(log2 k).
  always_comb begin
    case (k_r)
      4'd1: begin
        recip_k = 33'd4294967296;
        shift_k = 3'd0;
      end
      4'd2: begin
        recip_k = 33'd4294967296;
        shift_k = 3'd1;
      end
      4'd3: begin
        recip_k = 33'd5726623062;
        shift_k = 3'd2;
      end
      4'd4: begin
        recip_k = 33'd4294967296;
        shift_k = 3'd2;
      end
      4'd5: begin
        recip_k = 33'd6871947674;
        shift_k = 3'd3;
      end
      4'd6: begin
        recip_k = 33'd5726623062;
        shift_k = 3'd3;
      end
      4'd7: begin
        recip_k = 33'd4908534053;
        shift_k = 3'd3;
      end
      4'd8: begin
        recip_k = 33'd4294967296;
        shift_k = 3'd3;
      end
      4'd9: begin
        recip_k = 33'd7635497416;
        shift_k = 3'd4;
      end
      4'd10: begin
        recip_k = 33'd6871947674;
        shift_k = 3'd4;
      end
      4'd11: begin
        recip_k = 33'd6247225158;
        shift_k = 3'd4;
      end
      4'd12: begin
        recip_k = 33'd5726623062;
        shift_k = 3'd4;
      end
      default: begin
        recip_k = 33'd4294967296;
        shift_k = 3'd0;
      end
    endcase
    hp_q = 32'((mul_r >> shift_k) >> 32);
  end

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      dwne_pkg::OP_EX_MUL: begin
        mul_a = {1'b0, cmd.exp_sel ? cfg.end_time : cfg.start_time};
        mul_b = dwne_pkg::INV_TAU_LN2_Q32;
      end
      dwne_pkg::OP_EX_MULG: begin
        mul_a = {1'b0, f_r};
        mul_b = dwne_pkg::LN2_Q32;
      end
      dwne_pkg::OP_HP_MUL: begin
        mul_a = acc_r;
        mul_b = g_r;
      end
      dwne_pkg::OP_HP_DIV: begin
        mul_a = recip_k;
        mul_b = mul_r[63:32];
      end
      dwne_pkg::OP_N0: begin
        mul_a = {1'b0, sum_fin_r[31:0]};
        mul_b = width_fin_r;
      end
      dwne_pkg::OP_N1: begin
        mul_a = {17'b0, sum_fin_r[47:32]};
        mul_b = width_fin_r;
      end
      dwne_pkg::OP_D0: begin
        mul_a = {7'b0, dwne_pkg::TAU_Q24};
        mul_b = frames_eff;
      end
      dwne_pkg::OP_D1: begin
        mul_a = {1'b0, mul_r[31:0]};
        mul_b = diff_r;
      end
      dwne_pkg::OP_D2: begin
        mul_a = {7'b0, den1_r[57:32]};
        mul_b = diff_r;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      mul_r <= mul_a * mul_b;
    end
  end

  always_comb begin
    xv     = mul_r[63:0] >> TIME_FRAC_BITS;
    acc_sh = acc_r >> n_r;
    if (n_big_r) begin
      e_val = '0;
    end else if (acc_sh[32]) begin
      e_val = 32'hFFFF_FFFF;
    end else begin
      e_val = acc_sh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      dwne_pkg::OP_EX_SPLIT: begin
        n_big_r <= (xv[63:32] >= 32'd33);
        n_r     <= xv[37:32];
        f_r     <= xv[31:0];
      end
      dwne_pkg::OP_EX_SETG: begin
        g_r   <= mul_r[63:32];
        acc_r <= {1'b1, 32'b0};
        k_r   <= dwne_pkg::EXP_TERMS;
      end
      dwne_pkg::OP_HP_ACC: begin
        acc_r <= {1'b1, 32'b0} - {1'b0, hp_q};
        k_r   <= k_r - 1'b1;
      end
      dwne_pkg::OP_EX_FIN: begin
        if (cmd.exp_sel) begin
          eb_r <= e_val;
        end else begin
          ea_r <= e_val;
        end
      end
      dwne_pkg::OP_CMP: begin
        diff_r <= ea_r - eb_r;
      end
      dwne_pkg::OP_N1: begin
        num_acc_r <= {16'b0, mul_r[63:0]};
      end
      dwne_pkg::OP_N2: begin
        num_acc_r <= num_acc_r + {mul_r[47:0], 32'b0};
      end
      dwne_pkg::OP_D1: begin
        den1_r <= mul_r[57:0];
      end
      dwne_pkg::OP_D2: begin
        den_acc_r <= {26'b0, mul_r[63:0]};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_iters = '0;
    case (cmd.op)
      dwne_pkg::OP_BIG_DIV: begin
        div_start = 1'b1;
        div_num   = {{(dwne_pkg::NUM_W-80){1'b0}}, num_acc_r} << NUM_SHIFT;
        div_den   = den_acc_r + {mul_r[57:0], 32'b0};
        div_iters = dwne_pkg::ITER_W'(dwne_pkg::NUM_W);
      end
      default: begin
      end
    endcase
  end

  dwne_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num_in (div_num),
    .den_in (div_den),
    .iters  (div_iters),
    .busy   (div_busy),
    .quot   (div_q),
    .sat    (div_sat)
  );

  always_ff @(posedge clk) begin
    if (cmd.op == dwne_pkg::OP_LOAD_OUT) begin
      if (pre_status_r != dwne_pkg::ST_OK) begin
        status_r <= pre_status_r;
        norm_r   <= '0;
      end else if (ea_r <= eb_r) begin
        status_r <= dwne_pkg::ST_ZERO_WIN;
        norm_r   <= '0;
      end else begin
        status_r <= dwne_pkg::ST_OK;
        norm_r   <= div_sat ? MAX48 : div_q;
      end
    end
  end

  assign sts.pre_bad  = (pre_status_r != dwne_pkg::ST_OK);
  assign sts.zero_win = (ea_r <= eb_r);
  assign sts.k_last   = (k_r == 4'd1);
  assign sts.div_busy = div_busy;

  assign norm_constant = norm_r;
  assign status        = status_r;

endmodule

`default_nettype wire

/* design/dwne_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module dwne_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           last_bin,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output dwne_pkg::cmd_t      cmd,
  input  wire dwne_pkg::sts_t sts
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CHK   = 5'd1;
  localparam logic [4:0] S_EXM   = 5'd2;
  localparam logic [4:0] S_EXS   = 5'd3;
  localparam logic [4:0] S_EXMG  = 5'd4;
  localparam logic [4:0] S_EXG   = 5'd5;
  localparam logic [4:0] S_HPM   = 5'd6;
  localparam logic [4:0] S_HPD   = 5'd7;
  localparam logic [4:0] S_HPA   = 5'd9;
  localparam logic [4:0] S_EXF   = 5'd10;
  localparam logic [4:0] S_CMP   = 5'd11;
  localparam logic [4:0] S_N0    = 5'd12;
  localparam logic [4:0] S_N1    = 5'd13;
  localparam logic [4:0] S_N2    = 5'd14;
  localparam logic [4:0] S_D0    = 5'd15;
  localparam logic [4:0] S_D1    = 5'd16;
  localparam logic [4:0] S_D2    = 5'd17;
  localparam logic [4:0] S_BD    = 5'd18;
  localparam logic [4:0] S_BW    = 5'd19;
  localparam logic [4:0] S_RES   = 5'd20;

  logic [4:0] state_r, state_nxt;
  logic       sel_r, sel_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = dwne_pkg::OP_NONE;
    cmd.exp_sel   = sel_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = dwne_pkg::OP_BIN;
          if (last_bin) begin
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        sel_nxt   = 1'b0;
        state_nxt = sts.pre_bad ? S_RES : S_EXM;
      end
      S_EXM: begin
        cmd.op    = dwne_pkg::OP_EX_MUL;
        state_nxt = S_EXS;
      end
      S_EXS: begin
        cmd.op    = dwne_pkg::OP_EX_SPLIT;
        state_nxt = S_EXMG;
      end
      S_EXMG: begin
        cmd.op    = dwne_pkg::OP_EX_MULG;
        state_nxt = S_EXG;
      end
      S_EXG: begin
        cmd.op    = dwne_pkg::OP_EX_SETG;
        state_nxt = S_HPM;
      end
      S_HPM: begin
        cmd.op    = dwne_pkg::OP_HP_MUL;
        state_nxt = S_HPD;
      end
      S_HPD: begin
        cmd.op    = dwne_pkg::OP_HP_DIV;
        state_nxt = S_HPA;
      end
      S_HPA: begin
        cmd.op    = dwne_pkg::OP_HP_ACC;
        state_nxt = sts.k_last ? S_EXF : S_HPM;
      end
      S_EXF: begin
        cmd.op = dwne_pkg::OP_EX_FIN;
        if (sel_r) begin
          state_nxt = S_CMP;
        end else begin
          sel_nxt   = 1'b1;
          state_nxt = S_EXM;
        end
      end
      S_CMP: begin
        cmd.op    = dwne_pkg::OP_CMP;
        state_nxt = sts.zero_win ? S_RES : S_N0;
      end
      S_N0: begin
        cmd.op    = dwne_pkg::OP_N0;
        state_nxt = S_N1;
      end
      S_N1: begin
        cmd.op    = dwne_pkg::OP_N1;
        state_nxt = S_N2;
      end
      S_N2: begin
        cmd.op    = dwne_pkg::OP_N2;
        state_nxt = S_D0;
      end
      S_D0: begin
        cmd.op    = dwne_pkg::OP_D0;
        state_nxt = S_D1;
      end
      S_D1: begin
        cmd.op    = dwne_pkg::OP_D1;
        state_nxt = S_D2;
      end
      S_D2: begin
        cmd.op    = dwne_pkg::OP_D2;
        state_nxt = S_BD;
      end
      S_BD: begin
        cmd.op    = dwne_pkg::OP_BIG_DIV;
        state_nxt = S_BW;
      end
      S_BW: begin
        if (!sts.div_busy) begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = dwne_pkg::OP_LOAD_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* sim/tb_decay_window_normalisation_estimate_unit.sv */
`timescale 1ns / 1ps

module tb_decay_window_normalisation_estimate_unit;

  localparam int unsigned TFB        = dwne_pkg::TIME_FRAC_BITS_DEF;
  localparam int unsigned OFB        = dwne_pkg::OUT_FRAC_BITS_DEF;
  localparam int unsigned BIN_LIMIT  = dwne_pkg::MAX_BINS_DEF;
  localparam logic [47:0] MAX48      = 48'hFFFF_FFFF_FFFF;
  localparam int          IDLE_LIMIT = 20000;
  localparam int          HOLD_CYCLES = 3000;
  localparam int          RESET_ROWS = 4;
  localparam int          ITEM_GOAL  = 850;

  typedef struct {
    logic [31:0] left;
    logic [31:0] right;
    logic [31:0] count;
    logic        last;
    bit          typed;
    logic [47:0] norm;
    logic [1:0]  status;
  } bin_row_t;

  typedef struct {
    logic [47:0] norm;
    logic [1:0]  status;
  } estimate_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_bin_left_edge = '0;
  logic [31:0] in_bin_right_edge = '0;
  logic [31:0] in_bin_count = '0;
  logic        in_last_bin = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [47:0] out_norm_constant;
  logic [1:0]  out_status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  decay_window_normalisation_estimate_unit i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_bin_left_edge, .in_bin_right_edge,
    .in_bin_count, .in_last_bin, .out_valid, .out_stall, .out_norm_constant,
    .out_status, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk = ~clk;

  // Shadow of the block's window registers and histogram state.
  logic [31:0] win_start = '0;
  logic [31:0] win_end = '0;
  logic [31:0] frame_total = 32'd1;
  logic [47:0] acc_counts = '0;
  int unsigned bins_in_hist = 0;
  logic [31:0] width_of_first = '0;
  bit          start_hit = 0;
  bit          end_hit = 0;

  estimate_t   pending_estimates[$];
  int          errors = 0;
  int          bins_taken = 0;
  int          estimates_seen = 0;
  int          cycle = 0;
  int          last_activity = 0;
  bit          hold_req = 0;
  bit          hold_taken = 0;
  int          stall_left = 0;

  function automatic logic [31:0] decay_factor(logic [31:0] t);
    logic [63:0] x;
    logic [63:0] g;
    logic [63:0] acc;
    logic [63:0] p;
    x = (64'(t) * 64'(dwne_pkg::INV_TAU_LN2_Q32)) >> TFB;
    if (x[63:32] >= 33) return '0;
    g = (64'(x[31:0]) * 64'(dwne_pkg::LN2_Q32)) >> 32;
    acc = 64'h1_0000_0000;
    for (int k = int'(dwne_pkg::EXP_TERMS); k >= 1; k--) begin
      p = (g * acc) >> 32;
      acc = 64'h1_0000_0000 - p / 64'(k);
    end
    acc = acc >> x[63:32];
    if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
    return acc[31:0];
  endfunction

  function automatic logic [47:0] scaled_quotient(logic [47:0] sum, logic [31:0] width,
                                                  logic [31:0] frames, logic [31:0] diff);
    logic [255:0] num;
    logic [255:0] den;
    logic [255:0] q;
    num = (256'(sum) * 256'(width)) << (56 + OFB - TFB);
    den = 256'(dwne_pkg::TAU_Q24) * 256'(frames) * 256'(diff);
    q = num / den;
    return (q > 256'(MAX48)) ? MAX48 : q[47:0];
  endfunction

  // Advances the shadow histogram by one bin; returns 1 with the estimate on a last bin.
  function automatic bit absorb_bin(bin_row_t b, output estimate_t est);
    bit          first;
    bit          start_ok;
    logic [48:0] total;
    logic [31:0] ea;
    logic [31:0] eb;
    first = (bins_in_hist == 0);
    start_ok = first ? (b.left > win_start) : (b.left >= win_start);
    est.norm = '0;
    est.status = dwne_pkg::ST_OK;
    if (first) width_of_first = (b.right >= b.left) ? b.right - b.left : '0;
    if (start_ok) start_hit = 1;
    if ((!first && b.right <= win_end) || (b.last && b.right < win_end)) end_hit = 1;
    if (start_ok && b.right <= win_end) begin
      total = 49'(acc_counts) + 49'(b.count);
      acc_counts = total[48] ? MAX48 : total[47:0];
    end
    if (bins_in_hist < BIN_LIMIT) bins_in_hist++;
    if (!b.last) return 0;
    if (!start_hit) est.status = dwne_pkg::ST_NO_START;
    else if (!end_hit) est.status = dwne_pkg::ST_NO_END;
    else begin
      ea = decay_factor(win_start);
      eb = decay_factor(win_end);
      if (ea <= eb) est.status = dwne_pkg::ST_ZERO_WIN;
      else est.norm = scaled_quotient(acc_counts, width_of_first,
                                      (frame_total == 0) ? 32'd1 : frame_total, ea - eb);
    end
    acc_counts = '0;
    bins_in_hist = 0;
    width_of_first = '0;
    start_hit = 0;
    end_hit = 0;
    return 1;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx[1:0], 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      dwne_pkg::CFG_START:  win_start = value;
      dwne_pkg::CFG_END:    win_end = value;
      dwne_pkg::CFG_FRAMES: frame_total = value;
      default: ;
    endcase
  endtask

  task automatic set_window(logic [31:0] s, logic [31:0] e, logic [31:0] f);
    write_reg(dwne_pkg::CFG_START, s);
    write_reg(dwne_pkg::CFG_END, e);
    write_reg(dwne_pkg::CFG_FRAMES, f);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_bin(bin_row_t b);
    estimate_t est;
    in_valid <= 1'b1;
    in_bin_left_edge <= b.left;
    in_bin_right_edge <= b.right;
    in_bin_count <= b.count;
    in_last_bin <= b.last;
    do @(posedge clk); while (in_stall);
    bins_taken++;
    last_activity = cycle;
    if (absorb_bin(b, est)) begin
      if (b.typed) begin
        est.norm = b.norm;
        est.status = b.status;
      end
      pending_estimates.push_back(est);
    end
  endtask

  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_histogram(int nbins, bit paced);
    bin_row_t    b;
    logic [31:0] w;
    logic [31:0] edge_pos;
    int          r;
    w = (($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 32'h40000));
    edge_pos = win_start - w * $urandom_range(0, 2) + $urandom_range(0, 1);
    b.typed = 0;
    for (int i = 0; i < nbins; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        b.left = $urandom;
        b.right = $urandom;
      end else begin
        b.left = edge_pos;
        b.right = edge_pos + w;
        edge_pos = b.right;
      end
      r = $urandom_range(0, 99);
      b.count = (r < 4) ? 32'hFFFF_FFFF : (r < 8) ? 32'd0 :
                (r < 30) ? $urandom : $urandom_range(0, 5000);
      b.last = (i == nbins - 1) || ($urandom_range(0, 199) == 0);
      send_bin(b);
      if (paced) sender_gap();
    end
  endtask

  bin_row_t directed_rows[] = '{
    '{32'd1, 32'd0, 32'd5, 1'b1, 1'b1, 48'd0, dwne_pkg::ST_NO_END},
    '{32'd0, 32'd10, 32'd7, 1'b1, 1'b1, 48'd0, dwne_pkg::ST_NO_START},
    '{32'd1, 32'd0, 32'd3, 1'b0, 1'b0, 48'd0, dwne_pkg::ST_OK},
    '{32'd2, 32'd0, 32'd4, 1'b1, 1'b1, 48'd0, dwne_pkg::ST_ZERO_WIN},
    '{32'h10000, 32'h18000, 32'd100, 1'b0, 1'b0, 48'd0, dwne_pkg::ST_OK},
    '{32'h18000, 32'h20000, 32'd200, 1'b0, 1'b0, 48'd0, dwne_pkg::ST_OK},
    '{32'h20000, 32'h28000, 32'hFFFF_FFFF, 1'b0, 1'b0, 48'd0, dwne_pkg::ST_OK},
    '{32'h78000, 32'h80000, 32'd50, 1'b1, 1'b0, 48'd0, dwne_pkg::ST_OK},
    '{32'h30000, 32'h20000, 32'd1000, 1'b0, 1'b0, 48'd0, dwne_pkg::ST_OK},
    '{32'h40000, 32'h48000, 32'd10, 1'b1, 1'b0, 48'd0, dwne_pkg::ST_OK},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 48'd0, dwne_pkg::ST_OK},
    '{32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 48'd0, dwne_pkg::ST_OK},
    '{32'h20000, 32'h40000, 32'd12345, 1'b1, 1'b0, 48'd0, dwne_pkg::ST_OK},
    '{32'h80000, 32'h90000, 32'd77, 1'b1, 1'b0, 48'd0, dwne_pkg::ST_OK},
    '{32'd0, 32'h8000, 32'd1, 1'b1, 1'b0, 48'd0, dwne_pkg::ST_OK}
  };

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1;
      stall_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_stall <= 1'b0;
      end else if (r < 95) begin
        stall_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else if (r < 98) begin
        stall_left = $urandom_range(20, 80);
        out_stall <= 1'b1;
      end else begin
        stall_left = 0;
        out_stall <= 1'b0;
        repeat ($urandom_range(50, 200)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      estimate_t want;
      estimates_seen++;
      last_activity = cycle;
      if (pending_estimates.size() == 0) begin
        errors++;
        $display("%0t: unexpected estimate norm=%h status=%0d", $time,
                 out_norm_constant, out_status);
      end else begin
        want = pending_estimates.pop_front();
        if (out_norm_constant !== want.norm) begin
          errors++;
          $display("%0t: norm_constant expected %h got %h", $time, want.norm,
                   out_norm_constant);
        end
        if (out_status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle++;
    if (cycle - last_activity > IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("decay_window_normalisation_estimate_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int       items;
    int       phase_items;
    int       phase;
    int       nb;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first four rows, which hold the typed ones, run against the reset window; the rest against a fixed window.
    foreach (directed_rows[i]) begin
      if (i == RESET_ROWS) begin
        drain();
        set_window(32'h10000, 32'h80000, 32'd1000);
      end
      send_bin(directed_rows[i]);
      sender_gap();
    end
    drain();

    items = 0;
    phase = 0;
    while (items < ITEM_GOAL) begin
      case (phase)
        0: set_window(32'd0, 32'hFFFF_FFFF, 32'd1);
        1: set_window(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: set_window(32'h20000, 32'h10000, 32'd0);
        3: set_window(32'd0, 32'h40000, 32'd0);
        default: begin
          logic [31:0] s;
          s = $urandom_range(0, 32'hC0000);
          set_window(s, s + $urandom_range(0, 32'h300000),
                     ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(1, 1000));
        end
      endcase
      if (phase == 5) hold_req = 1;
      phase_items = 0;
      while (phase_items < 85) begin
        nb = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        send_histogram(nb, phase != 5);
        phase_items += nb;
      end
      items += phase_items;
      drain();
      phase++;
    end

    in_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Fed %0d bins over %0d window settings, checked %0d estimates.",
             bins_taken, phase + 2, estimates_seen);
    $display("Covered every status code, reversed and stray bins, and a long output hold-off.");
    if (errors == 0) begin
      $display("decay_window_normalisation_estimate_unit regression: pass");
    end else begin
      $display("decay_window_normalisation_estimate_unit regression: fail");
    end
    $finish;
  end

endmodule
